// ===== rtl/dfcc_pkg.sv =====
`default_nettype none

package dfcc_pkg;

  // link control codes
  localparam logic [7:0] CODE_SOH = 8'h01;
  localparam logic [7:0] CODE_EOT = 8'h04;
  localparam logic [7:0] CODE_DLE = 8'h10;

  // register map, selected by paddr[2]
  localparam logic REG_CRC_POLY = 1'b0;
  localparam logic REG_CRC_INIT = 1'b1;

  localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
  localparam logic [15:0] CRC_INIT_RESET = 16'h0000;

  // configuration seen by the datapath
  typedef struct packed {
    logic [15:0] crc_poly;
    logic [15:0] crc_init;
  } dfcc_cfg_t;

  // one result word
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_strobe;
    logic [7:0] payload_index;
    logic       frame_end;
    logic       frame_good;
    logic [8:0] frame_bytes;
  } dfcc_res_t;

endpackage

`default_nettype wire

// ===== rtl/dfcc_in_if.sv =====
`default_nettype none

interface dfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/dfcc_out_if.sv =====
`default_nettype none

interface dfcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_strobe;
  logic [7:0] payload_index;
  logic       frame_end;
  logic       frame_good;
  logic [8:0] frame_bytes;

  modport source (
    output valid, output payload_byte, output payload_strobe, output payload_index,
    output frame_end, output frame_good, output frame_bytes, input ready
  );
  modport sink (
    input valid, input payload_byte, input payload_strobe, input payload_index,
    input frame_end, input frame_good, input frame_bytes, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/dfcc_cfg_regs.sv =====
`default_nettype none

module dfcc_cfg_regs import dfcc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready,
  output      dfcc_cfg_t   cfg
);

  logic [15:0] poly_r;
  logic [15:0] init_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= CRC_POLY_RESET;
      init_r <= CRC_INIT_RESET;
    end else if (wr_en) begin
      case (cfg_paddr[2])
        REG_CRC_POLY: poly_r <= cfg_pwdata[15:0];
        REG_CRC_INIT: init_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (cfg_paddr[2])
      REG_CRC_POLY: cfg_prdata = {16'h0000, poly_r};
      REG_CRC_INIT: cfg_prdata = {16'h0000, init_r};
      default:      cfg_prdata = 32'h0000_0000;
    endcase
  end

  assign cfg.crc_poly = poly_r;
  assign cfg.crc_init = init_r;

endmodule

`default_nettype wire

// ===== rtl/dfcc_crc_byte.sv =====
`default_nettype none

module dfcc_crc_byte (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  input  wire logic [15:0] poly,
  output      logic [15:0] crc_out
);

  // msb-first crc-16, one byte folded in eight bit steps
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ===== rtl/dfcc_deframe.sv =====
`default_nettype none

module dfcc_deframe import dfcc_pkg::*; #(
  parameter int MAX_FRAME = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire dfcc_cfg_t  cfg,
  output      dfcc_res_t  res
);

  localparam int CW = $clog2(MAX_FRAME);
  localparam logic [CW-1:0] WRAP_AT = CW'(MAX_FRAME - 2);

  logic          esc_r, esc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    h0_r, h0_nxt;
  logic [7:0]    h1_r, h1_nxt;

  logic          wrap;
  logic [CW-1:0] cnt_b;
  logic [15:0]   crc_b;
  logic [7:0]    h0_b;
  logic [7:0]    h1_b;
  logic [15:0]   crc_fed;
  logic          store;
  logic [CW+8:0] cnt_ext;

  // frame restarts when the length wraps
  assign wrap  = (cnt_r >= WRAP_AT);
  assign cnt_b = wrap ? '0 : cnt_r;
  assign crc_b = wrap ? cfg.crc_init : crc_r;
  assign h0_b  = wrap ? 8'h00 : h0_r;
  assign h1_b  = wrap ? 8'h00 : h1_r;

  assign cnt_ext = {9'b0, cnt_b};

  dfcc_crc_byte u_crc (
    .crc_in  (crc_b),
    .data    (h0_b),
    .poly    (cfg.crc_poly),
    .crc_out (crc_fed)
  );

  // byte classification and state update
  always_comb begin
    esc_nxt = esc_r;
    cnt_nxt = cnt_b;
    crc_nxt = crc_b;
    h0_nxt  = h0_b;
    h1_nxt  = h1_b;
    store   = 1'b0;
    res     = '0;
    if (esc_r) begin
      store = 1'b1;
    end else begin
      case (rx_byte)
        CODE_SOH: begin
          cnt_nxt = '0;
          crc_nxt = cfg.crc_init;
          h0_nxt  = 8'h00;
          h1_nxt  = 8'h00;
        end
        CODE_EOT: begin
          res.frame_end   = 1'b1;
          res.frame_bytes = cnt_ext[8:0];
          res.frame_good  = (cnt_b > CW'(2)) && (crc_b == {h1_b, h0_b});
        end
        CODE_DLE: begin
          esc_nxt = 1'b1;
        end
        default: begin
          store = 1'b1;
        end
      endcase
    end
    if (store) begin
      esc_nxt            = 1'b0;
      res.payload_byte   = rx_byte;
      res.payload_strobe = 1'b1;
      res.payload_index  = cnt_ext[7:0];
      if (cnt_b >= CW'(2)) begin
        crc_nxt = crc_fed;
      end
      h0_nxt  = h1_b;
      h1_nxt  = rx_byte;
      cnt_nxt = cnt_b + CW'(1);
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
      cnt_r <= '0;
      crc_r <= CRC_INIT_RESET;
      h0_r  <= 8'h00;
      h1_r  <= 8'h00;
    end else if (step) begin
      esc_r <= esc_nxt;
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
      h0_r  <= h0_nxt;
      h1_r  <= h1_nxt;
    end
  end

  // count stays inside the frame window
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= WRAP_AT)
    else $error("byte count beyond wrap point");

  // an escape is always consumed by the next word
  a_esc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step && esc_r) |=> !esc_r)
    else $error("escape not consumed");

  // a stored byte advances the count by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (step && store && !wrap) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("count did not advance on stored byte");

endmodule

`default_nettype wire

// ===== rtl/dle_frame_deframer_crc_check.sv =====
`default_nettype none

// Receive deframer: SOH/EOT framing, DLE byte unstuffing and a CRC-16 check.
// in_ch carries one raw link byte per word; out_ch carries exactly one result
// word per input word: the unescaped payload byte with its index and strobe,
// at an unescaped EOT the frame end flag, length and CRC verdict, else empty.
// The last two payload bytes of a frame are its CRC, low byte first.
// Configuration is an APB-style port with crc_poly at 0x0 and crc_init at 0x4.
// The user must write it only while no word is in flight; the block does not
// enforce this. A word passes an input register, then the frame logic with a
// one-byte CRC update feeding the result register. Throughput is one word per
// cycle unless out_ch stalls; the eight-step CRC fold sets the critical path.
// Reset (rst_n low, synchronous) empties both registers, clears escape,
// count and held bytes and loads the CRC register reset values. When the
// receiver stalls the result register holds; an empty input register takes
// one more word, after which in_ch.ready drops until out_ch drains.
module dle_frame_deframer_crc_check import dfcc_pkg::*; #(
  parameter int MAX_FRAME = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dfcc_in_if.sink          in_ch,
  dfcc_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);

  dfcc_cfg_t  cfg;
  dfcc_res_t  res;
  dfcc_res_t  res_r;
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       out_v_r;
  logic       adv;

  dfcc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // handshake: stage advances when result register is free
  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  dfcc_deframe #(
    .MAX_FRAME (MAX_FRAME)
  ) u_deframe (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.payload_byte   = res_r.payload_byte;
  assign out_ch.payload_strobe = res_r.payload_strobe;
  assign out_ch.payload_index  = res_r.payload_index;
  assign out_ch.frame_end      = res_r.frame_end;
  assign out_ch.frame_good     = res_r.frame_good;
  assign out_ch.frame_bytes    = res_r.frame_bytes;

  // a good frame is only reported at frame end
  a_good_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (!res_r.frame_good || res_r.frame_end))
    else $error("frame_good without frame_end");

  // a word is either payload or frame end, never both
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(res_r.payload_strobe && res_r.frame_end))
    else $error("payload and frame end in one word");

  // the result register is never overwritten while stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |-> !adv)
    else $error("result overwritten under stall");

endmodule

`default_nettype wire
